@@ hdl/prf_pkg.sv @@
`default_nettype none
package prf_pkg;

	// queue and divider geometry
	localparam int QueueDepthDef = 16;
	localparam int MsW           = 16;
	localparam int GameMsW       = 10;
	localparam int TicksW        = 16;
	localparam int MaxSizeW      = 5;
	localparam int CfgDataW      = 16;
	localparam int CfgIdxW       = 2;
	localparam int ValW          = 32;
	localparam int IvW           = 17;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_INIT_TICKS = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_INIT_MS    = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_GAME_MS    = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_MAX_SIZE   = 2'd3;

	// configuration reset values
	localparam logic signed [TicksW-1:0] InitTicksRst = 16'sd0;
	localparam logic [MsW-1:0]           InitMsRst    = 16'd0;
	localparam logic [GameMsW-1:0]       GameMsRst    = 10'd10;
	localparam logic [MaxSizeW-1:0]      MaxSizeRst   = 5'd16;

	// saturation limits for the set commands
	localparam logic signed [ValW-1:0] TicksMin = -32'sd32768;
	localparam logic signed [ValW-1:0] TicksMax = 32'sd32767;
	localparam logic signed [ValW-1:0] MsMax    = 32'sd65535;

	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_PUSH      = 3'd1,
		CMD_SET_TICKS = 3'd2,
		CMD_SET_MS    = 3'd3,
		CMD_RESTORE   = 3'd4,
		CMD_CLEAR     = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_REL
	} state_t;

	localparam logic KIND_RELEASE  = 1'b0;
	localparam logic KIND_OVERFLOW = 1'b1;

endpackage
`default_nettype wire

@@ hdl/prf_ram.sv @@
`default_nettype none
module prf_ram #(
	parameter int WIDTH = prf_pkg::ValW,
	parameter int DEPTH = prf_pkg::QueueDepthDef,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	import prf_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ hdl/prf_div.sv @@
`default_nettype none
module prf_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [prf_pkg::MsW-1:0]     dividend,
	input  wire logic [prf_pkg::GameMsW-1:0] divisor,
	output logic                             done,
	output logic      [prf_pkg::MsW-1:0]     quotient
);
	import prf_pkg::*;

	localparam int CntW = $clog2(MsW);

	logic                busy_q;
	logic                done_q;
	logic [CntW-1:0]     cnt_q;
	logic [GameMsW-1:0]  den_q;
	logic [GameMsW-1:0]  rem_q;
	logic [MsW-1:0]      quo_q;
	logic [GameMsW:0]    trial;
	logic [GameMsW:0]    diff;
	logic                fits;

	// one restoring step per cycle, quotient bits shift in from the right
	always_comb begin
		trial = {rem_q, quo_q[MsW-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(MsW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[GameMsW-1:0] : trial[GameMsW-1:0];
			quo_q <= {quo_q[MsW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ hdl/paced_release_fifo.sv @@
`default_nettype none
// paced release fifo: a bounded queue of signed 32-bit values that lets one
// value out per tick command, no sooner than the current interval after the
// previous release. the interval is max(1, interval_ticks + interval_ms /
// game_interval_ms), the quotient coming from a bit-serial divider.
// a command is taken when start is high and busy is low. push, the set and
// restore commands, clear, idle codes and ticks that release nothing keep
// busy high for 1 cycle, in ST_EXEC; a tick that releases keeps busy high
// through ST_EXEC, ST_DIV (16 divider steps) and ST_REL.
// each result (a released value, or a push refused because the queue is at
// the clamped max_queue_size) appears on kind/value_res for exactly one cycle,
// flagged by result_valid, as busy falls. the receiver cannot stall, so it must
// take every result in the cycle it is shown. configuration writes go in at
// any edge with cfg_wr_en high but are only meant for times when busy is low
// and no result is pending. queue storage is a ram with registered read, no
// clearing pass: entries are only read after they have been written.
module paced_release_fifo #(
	parameter int QUEUE_DEPTH = prf_pkg::QueueDepthDef
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command channel
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [2:0]                          command,
	input  wire logic signed [prf_pkg::ValW-1:0]     value,
	// result channel
	output logic                                     result_valid,
	output logic                                     kind,
	output logic signed [prf_pkg::ValW-1:0]          value_res,
	// configuration write port
	input  wire logic                                cfg_wr_en,
	input  wire logic [prf_pkg::CfgIdxW-1:0]         cfg_index,
	input  wire logic [prf_pkg::CfgDataW-1:0]        cfg_data
);
	import prf_pkg::*;

	localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OccW = $clog2(QUEUE_DEPTH + 1);
	localparam int CmpW = (OccW > MaxSizeW) ? OccW : MaxSizeW;
	localparam int SumW = ((AW > OccW) ? AW : OccW) + 1;

	// configuration registers
	logic signed [TicksW-1:0] init_ticks_q;
	logic [MsW-1:0]           init_ms_q;
	logic [GameMsW-1:0]       game_ms_q;
	logic [MaxSizeW-1:0]      max_size_q;

	// queue and pacing state
	logic [AW-1:0]            head_q;
	logic [OccW-1:0]          occ_q;
	logic [ValW-1:0]          now_q;
	logic [ValW-1:0]          tgt_q;
	logic                     tset_q;
	logic signed [TicksW-1:0] iv_ticks_q;
	logic [MsW-1:0]           iv_ms_q;
	logic [IvW-1:0]           iv_q;

	// latched command
	cmd_t                     cmd_q;
	logic signed [ValW-1:0]   val_q;

	// result register
	logic                     res_valid_q;
	logic                     res_kind_q;
	logic signed [ValW-1:0]   res_val_q;

	state_t                   state_q;
	state_t                   state_d;

	logic                     div_start;
	logic                     div_done;
	logic [MsW-1:0]           div_quo;
	logic [GameMsW-1:0]       divisor;
	logic                     ram_we;
	logic [AW-1:0]            waddr;
	logic [ValW-1:0]          head_data;
	logic                     rel_ok;
	logic                     full;
	logic [CmpW-1:0]          cap;
	logic [SumW-1:0]          wsum;
	logic [AW-1:0]            head_next;
	logic signed [IvW:0]      iv_sum;
	logic [ValW:0]            tgt_sum;

	// ---------------------------------------------------------------
	// derived values
	// ---------------------------------------------------------------

	// zero tick length counts as one
	assign divisor = (game_ms_q == '0) ? GameMsW'(1) : game_ms_q;

	// usable capacity: max_queue_size clamped to 1..QUEUE_DEPTH
	always_comb begin
		if (max_size_q == '0) begin
			cap = CmpW'(1);
		end else if (CmpW'(max_size_q) > CmpW'(QUEUE_DEPTH)) begin
			cap = CmpW'(QUEUE_DEPTH);
		end else begin
			cap = CmpW'(max_size_q);
		end
	end

	assign full = CmpW'(occ_q) >= cap;

	// head is due when no target exists yet or time has reached it
	assign rel_ok = (occ_q != '0) && (!tset_q || (tgt_q <= now_q));

	// tail slot, wrapping at the queue depth
	assign wsum  = SumW'(head_q) + SumW'(occ_q);
	assign waddr = (wsum >= SumW'(QUEUE_DEPTH)) ? AW'(wsum - SumW'(QUEUE_DEPTH)) : AW'(wsum);

	assign head_next = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	// interval before the floor of one tick
	assign iv_sum = (IvW+1)'(iv_ticks_q) + $signed({2'b00, div_quo});

	// next target, saturating at the top of the time range
	assign tgt_sum = {1'b0, now_q} + (ValW+1)'(iv_q);

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// only a releasing tick needs the divider
				if (cmd_q == CMD_TICK && rel_ok) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_REL;
				end
			end
			ST_REL: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		div_start = 1'b0;
		ram_we    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_EXEC: begin
				div_start = (cmd_q == CMD_TICK) && rel_ok;
				ram_we    = (cmd_q == CMD_PUSH) && !full;
			end
			ST_DIV, ST_REL: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command latch on transfer
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd_t'(command);
			val_q <= value;
		end
	end

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_ticks_q <= InitTicksRst;
			init_ms_q    <= InitMsRst;
			game_ms_q    <= GameMsRst;
			max_size_q   <= MaxSizeRst;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_INIT_TICKS: init_ticks_q <= $signed(cfg_data[TicksW-1:0]);
				REG_INIT_MS:    init_ms_q    <= cfg_data[MsW-1:0];
				REG_GAME_MS:    game_ms_q    <= cfg_data[GameMsW-1:0];
				REG_MAX_SIZE:   max_size_q   <= cfg_data[MaxSizeW-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// queue, time and interval state
	// ---------------------------------------------------------------

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			occ_q       <= '0;
			now_q       <= '0;
			tgt_q       <= '0;
			tset_q      <= 1'b0;
			iv_ticks_q  <= InitTicksRst;
			iv_ms_q     <= InitMsRst;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (state_q == ST_EXEC) begin
				case (cmd_q)
					CMD_TICK: begin
						// a releasing tick advances time at the end of ST_REL
						if (!rel_ok && now_q != '1) begin
							now_q <= now_q + 1'b1;
						end
					end
					CMD_PUSH: begin
						if (full) begin
							res_valid_q <= 1'b1;
						end else begin
							occ_q <= occ_q + 1'b1;
							if (!tset_q || tgt_q < now_q) begin
								tgt_q  <= now_q;
								tset_q <= 1'b1;
							end
						end
					end
					CMD_SET_TICKS: begin
						if (val_q < TicksMin) begin
							iv_ticks_q <= TicksMin[TicksW-1:0];
						end else if (val_q > TicksMax) begin
							iv_ticks_q <= TicksMax[TicksW-1:0];
						end else begin
							iv_ticks_q <= val_q[TicksW-1:0];
						end
					end
					CMD_SET_MS: begin
						if (val_q < 0) begin
							iv_ms_q <= '0;
						end else if (val_q > MsMax) begin
							iv_ms_q <= MsMax[MsW-1:0];
						end else begin
							iv_ms_q <= val_q[MsW-1:0];
						end
					end
					CMD_RESTORE: begin
						iv_ticks_q <= init_ticks_q;
						iv_ms_q    <= init_ms_q;
					end
					CMD_CLEAR: begin
						// target and interval stay as they are
						occ_q  <= '0;
						head_q <= '0;
					end
					default: ;
				endcase
			end else if (state_q == ST_REL) begin
				res_valid_q <= 1'b1;
				head_q      <= head_next;
				occ_q       <= occ_q - 1'b1;
				tgt_q       <= tgt_sum[ValW] ? '1 : tgt_sum[ValW-1:0];
				tset_q      <= 1'b1;
				if (now_q != '1) begin
					now_q <= now_q + 1'b1;
				end
			end
		end
	end

	// interval floor of one, and the result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_done) begin
			iv_q <= (iv_sum < 1) ? IvW'(1) : iv_sum[IvW-1:0];
		end
		if (state_q == ST_EXEC) begin
			res_kind_q <= KIND_OVERFLOW;
			res_val_q  <= val_q;
		end else if (state_q == ST_REL) begin
			res_kind_q <= KIND_RELEASE;
			res_val_q  <= $signed(head_data);
		end
	end

	// ---------------------------------------------------------------
	// divider and queue storage
	// ---------------------------------------------------------------

	prf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (iv_ms_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// read port sits on the head; data is long settled before a release
	prf_ram #(
		.WIDTH (ValW),
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (val_q),
		.raddr (head_q),
		.rdata (head_data)
	);

	assign result_valid = res_valid_q;
	assign kind         = res_kind_q;
	assign value_res    = res_val_q;

endmodule
`default_nettype wire

@@ verif/paced_release_fifo_tb.sv @@
`timescale 1ns / 1ps
module paced_release_fifo_tb;
	import prf_pkg::*;

	// unused command codes, the block must ignore them
	localparam logic [2:0] CMD_NOP_LO = 3'd6;
	localparam logic [2:0] CMD_NOP_HI = 3'd7;
	// cycles with no transfer at all before the run is declared hung
	localparam int HANG_LIMIT = 4000;
	// margin after a drain, longer than a releasing tick keeps busy high
	localparam int SETTLE_CYCLES = 30;

	typedef struct packed {
		logic              kind;
		logic signed [31:0] value;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// command channel
	logic              start = 1'b0;
	logic              busy;
	logic [2:0]        command = CMD_TICK;
	logic signed [31:0] value = '0;

	// result channel
	logic              result_valid;
	logic              kind;
	logic signed [31:0] value_res;

	// configuration port
	logic                cfg_wr_en = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = REG_INIT_TICKS;
	logic [CfgDataW-1:0] cfg_data = '0;

	always #5 clk = ~clk;

	paced_release_fifo dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.value        (value),
		.result_valid (result_valid),
		.kind         (kind),
		.value_res    (value_res),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ---------------------------------------------------------------
	// shadow copy of the queue state, updated at each accepted transfer
	// ---------------------------------------------------------------
	logic signed [31:0] held_values[$];
	logic [31:0]        clock_now = '0;
	logic [31:0]        release_at = '0;
	logic               release_armed = 1'b0;
	logic signed [15:0] pace_ticks_cur = InitTicksRst;
	logic [15:0]        pace_ms_cur = InitMsRst;

	// shadow configuration registers
	logic signed [15:0] init_ticks_cfg = InitTicksRst;
	logic [15:0]        init_ms_cfg = InitMsRst;
	logic [9:0]         tick_ms_cfg = GameMsRst;
	logic [4:0]         depth_limit_cfg = MaxSizeRst;

	// results still owed by the block, oldest first
	outcome_t owed_results[$];
	int       mismatches = 0;
	int       idle_cycles = 0;

	// a tick length of zero behaves as one
	function automatic int unsigned tick_ms_eff();
		return (tick_ms_cfg == 0) ? 1 : tick_ms_cfg;
	endfunction

	// occupancy at which pushes overflow, clamped to the real depth
	function automatic int unsigned queue_cap();
		if (depth_limit_cfg == 0)
			return 1;
		if (depth_limit_cfg > QueueDepthDef)
			return QueueDepthDef;
		return depth_limit_cfg;
	endfunction

	// release spacing in ticks, never below one
	function automatic longint release_gap();
		longint gap_ticks;
		gap_ticks = longint'(pace_ticks_cur) + longint'(pace_ms_cur) / longint'(tick_ms_eff());
		return (gap_ticks < 1) ? 1 : gap_ticks;
	endfunction

	// apply one accepted command to the shadow state, queue any result
	function automatic void predict_release(input logic [2:0] cmd, input logic signed [31:0] v);
		outcome_t   res;
		logic [63:0] next_at;
		case (cmd)
			CMD_TICK: begin
				// release only when something is held and the target is due
				if (held_values.size() > 0 && (!release_armed || release_at <= clock_now)) begin
					res.kind = KIND_RELEASE;
					res.value = held_values[0];
					held_values.delete(0);
					owed_results = {owed_results, res};
					next_at = {32'd0, clock_now} + 64'(release_gap());
					// target saturates instead of wrapping
					release_at = (next_at > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : next_at[31:0];
					release_armed = 1'b1;
				end
				if (clock_now != 32'hFFFF_FFFF)
					clock_now = clock_now + 1;
			end
			CMD_PUSH: begin
				if (held_values.size() >= queue_cap()) begin
					res.kind = KIND_OVERFLOW;
					res.value = v;
					owed_results = {owed_results, res};
				end else begin
					held_values = {held_values, v};
					// a stale target is pulled up to the present
					if (!release_armed || release_at < clock_now) begin
						release_at = clock_now;
						release_armed = 1'b1;
					end
				end
			end
			CMD_SET_TICKS: begin
				if (v < TicksMin)
					pace_ticks_cur = TicksMin[15:0];
				else if (v > TicksMax)
					pace_ticks_cur = TicksMax[15:0];
				else
					pace_ticks_cur = v[15:0];
			end
			CMD_SET_MS: begin
				if (v < 0)
					pace_ms_cur = '0;
				else if (v > MsMax)
					pace_ms_cur = MsMax[15:0];
				else
					pace_ms_cur = v[15:0];
			end
			CMD_RESTORE: begin
				pace_ticks_cur = init_ticks_cfg;
				pace_ms_cur = init_ms_cfg;
			end
			CMD_CLEAR: begin
				// target and interval are left alone
				held_values.delete();
			end
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch @%0t: %s", $time, msg);
	endtask

	// ---------------------------------------------------------------
	// result checker: the receiver never stalls, every strobe is a transfer
	// ---------------------------------------------------------------
	always @(posedge clk) begin : check_results
		outcome_t owed;
		if (arst_n && result_valid) begin
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0d value=%0d",
					kind, value_res));
			end else begin
				owed = owed_results[0];
				owed_results.delete(0);
				if (kind !== owed.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, owed.kind));
				if (value_res !== owed.value)
					report_mismatch($sformatf("value_res %0d, expected %0d",
						value_res, owed.value));
			end
		end
	end

	// hang detection: any transfer on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("FAIL paced_release_fifo");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	// present one command and wait for its transfer; start stays high so
	// back-to-back commands need no extra cycle
	task automatic issue(input logic [2:0] cmd, input logic signed [31:0] v);
		start <= 1'b1;
		command <= cmd;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_release(cmd, v);
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// mostly none or short, now and then a long gap
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// stop sending and wait until every owed result is in and the block is idle
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (owed_results.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write; cfg_wr_en is left high for the next one
	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_INIT_TICKS: init_ticks_cfg = data;
			REG_INIT_MS:    init_ms_cfg = data;
			REG_GAME_MS:    tick_ms_cfg = data[GameMsW-1:0];
			REG_MAX_SIZE:   depth_limit_cfg = data[MaxSizeW-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic load_config(input logic signed [15:0] ticks0, input logic [15:0] ms0,
			input logic [9:0] tick_ms, input logic [4:0] depth_limit);
		cfg_write(REG_INIT_TICKS, ticks0);
		cfg_write(REG_INIT_MS, ms0);
		cfg_write(REG_GAME_MS, CfgDataW'(tick_ms));
		cfg_write(REG_MAX_SIZE, CfgDataW'(depth_limit));
		cfg_wr_en <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// hand-picked sequence under reset configuration
	task automatic test_directed_cases();
		// tick with nothing held and no target yet
		issue(CMD_TICK, '0);
		// extreme values through the queue, back to back
		issue(CMD_PUSH, 32'sh7FFF_FFFF);
		issue(CMD_PUSH, 32'sh8000_0000);
		issue(CMD_TICK, 32'hFFFF_FFFF);
		issue(CMD_TICK, '0);
		// codes with no meaning
		issue(CMD_NOP_LO, 32'hFFFF_FFFF);
		issue(CMD_NOP_HI, '0);
		// saturation of both set commands at both ends
		issue(CMD_SET_TICKS, 32'sd40000);
		issue(CMD_SET_TICKS, -32'sd40000);
		issue(CMD_SET_MS, -32'sd1);
		issue(CMD_SET_MS, 32'sd70000);
		// interval of four ticks
		issue(CMD_SET_MS, 32'sd25);
		issue(CMD_SET_TICKS, 32'sd2);
		issue(CMD_PUSH, -32'sd1);
		issue(CMD_PUSH, 32'sd5);
		repeat (5) issue(CMD_TICK, $urandom);
		issue(CMD_RESTORE, $urandom);
		// clear drops held values but keeps the target
		issue(CMD_PUSH, 32'sd1);
		issue(CMD_PUSH, 32'sd2);
		issue(CMD_CLEAR, $urandom);
		issue(CMD_TICK, $urandom);
		issue(CMD_PUSH, 32'sd3);
		issue(CMD_TICK, $urandom);
	endtask

	// random traffic under one configuration, intervals kept short so that
	// releases keep flowing
	task automatic run_random_phase(input logic signed [15:0] ticks0, input logic [15:0] ms0,
			input logic [9:0] tick_ms, input logic [4:0] depth_limit, input int n_items);
		int                 sent;
		int                 r;
		int                 burst;
		bit                 gappy;
		logic signed [31:0] v;
		drain_results();
		load_config(ticks0, ms0, tick_ms, depth_limit);
		sent = 0;
		gappy = 1'b0;
		while (sent < n_items) begin
			// switch between idle-free stretches and gappy ones
			if ($urandom_range(0, 39) == 0)
				gappy = ~gappy;
			r = $urandom_range(0, 99);
			if (r < 3) begin
				// fill to the limit and often past it to force overflows
				burst = queue_cap() + $urandom_range(0, 2);
				repeat (burst) issue(CMD_PUSH, $urandom);
				sent += burst;
			end else begin
				if (r < 45) begin
					issue(CMD_PUSH, $urandom);
				end else if (r < 85) begin
					issue(CMD_TICK, $urandom);
				end else if (r < 89) begin
					// large negative values saturate low, which keeps the interval at one
					if ($urandom_range(0, 9) == 0)
						v = $urandom | 32'h8000_0000;
					else
						v = int'($urandom_range(0, 7)) - 3;
					issue(CMD_SET_TICKS, v);
				end else if (r < 93) begin
					if ($urandom_range(0, 9) == 0)
						v = $urandom | 32'h8000_0000;
					else
						v = $urandom_range(0, 3 * tick_ms_eff());
					issue(CMD_SET_MS, v);
				end else if (r < 95) begin
					issue(CMD_RESTORE, $urandom);
				end else if (r < 97) begin
					issue(CMD_CLEAR, $urandom);
				end else begin
					issue($urandom_range(0, 1) ? CMD_NOP_HI : CMD_NOP_LO, $urandom);
				end
				sent++;
			end
			if (gappy)
				hold_off(gap_len());
		end
	endtask

	// one phase per configuration, extremes first, then random settings
	task automatic test_random_phases();
		logic [9:0] tick_ms;
		run_random_phase(16'sd0, 16'd0, 10'd10, 5'd16, 250);
		run_random_phase(-16'sd32768, 16'hFFFF, 10'd1000, 5'd0, 250);
		run_random_phase(16'sd2, 16'd3, 10'd0, 5'd31, 250);
		run_random_phase(-16'sd1, 16'd20, 10'd1023, 5'd1, 250);
		repeat (2) begin
			tick_ms = $urandom_range(1, 1023);
			run_random_phase(16'(int'($urandom_range(0, 6)) - 3),
				16'($urandom_range(0, 4 * tick_ms)), tick_ms, 5'($urandom_range(0, 31)), 250);
		end
	endtask

	// largest possible interval; left for last since the target then
	// lies far beyond the end of the run
	task automatic test_long_interval();
		drain_results();
		load_config(16'sh7FFF, 16'hFFFF, 10'd1, 5'd16);
		issue(CMD_RESTORE, $urandom);
		issue(CMD_PUSH, $urandom);
		issue(CMD_PUSH, $urandom);
		repeat (12) issue(CMD_TICK, $urandom);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_phases();
		test_long_interval();
		drain_results();
		if (mismatches == 0)
			$display("PASS paced_release_fifo");
		else
			$display("FAIL paced_release_fifo");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/prf_pkg.sv
hdl/prf_ram.sv
hdl/prf_div.sv
hdl/paced_release_fifo.sv
verif/paced_release_fifo_tb.sv
